[hdl/kdbx_pkg.sv]
// Shared types and constants of the database header field parser.
// Holds the signature and cipher UUID tables, phase and error codes and the queue entry.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package kdbx_pkg;

	// Phase codes, also the state of the parser.
	localparam logic [2:0] PH_MAGIC   = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_ID      = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_LEN_HI  = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;
	localparam logic [2:0] PH_ERROR   = 3'd7;

	// Error codes.
	localparam logic [3:0] ERR_OK          = 4'd0;
	localparam logic [3:0] ERR_MAGIC       = 4'd1;
	localparam logic [3:0] ERR_VERSION     = 4'd2;
	localparam logic [3:0] ERR_CIPHER      = 4'd3;
	localparam logic [3:0] ERR_COMPRESSION = 4'd4;
	localparam logic [3:0] ERR_SEED_LEN    = 4'd5;
	localparam logic [3:0] ERR_ROUNDS_LEN  = 4'd6;
	localparam logic [3:0] ERR_IV_LEN      = 4'd7;
	localparam logic [3:0] ERR_START_LEN   = 4'd8;
	localparam logic [3:0] ERR_STREAM_LEN  = 4'd9;
	localparam logic [3:0] ERR_BAD_ID      = 4'd10;
	localparam logic [3:0] ERR_TRUNCATED   = 4'd11;

	// Header field ids.
	localparam logic [7:0] FID_END         = 8'd0;
	localparam logic [7:0] FID_COMMENT     = 8'd1;
	localparam logic [7:0] FID_CIPHER      = 8'd2;
	localparam logic [7:0] FID_COMPRESSION = 8'd3;
	localparam logic [7:0] FID_MASTER_SEED = 8'd4;
	localparam logic [7:0] FID_XFORM_SEED  = 8'd5;
	localparam logic [7:0] FID_ROUNDS      = 8'd6;
	localparam logic [7:0] FID_IV          = 8'd7;
	localparam logic [7:0] FID_STREAM_KEY  = 8'd8;
	localparam logic [7:0] FID_START_BYTES = 8'd9;
	localparam logic [7:0] FID_STREAM_ID   = 8'd10;

	// Required payload lengths.
	localparam logic [15:0] LEN_CIPHER = 16'd16;
	localparam logic [15:0] LEN_COMPR  = 16'd4;
	localparam logic [15:0] LEN_SEED   = 16'd32;
	localparam logic [15:0] LEN_ROUNDS = 16'd8;
	localparam logic [15:0] LEN_IV     = 16'd16;
	localparam logic [15:0] LEN_START  = 16'd32;
	localparam logic [15:0] LEN_SID    = 16'd4;

	localparam int MAGIC_LEN = 8;
	localparam int UUID_LEN  = 16;

	localparam logic [7:0] MAGIC [MAGIC_LEN] = '{
		8'h03, 8'hd9, 8'ha2, 8'h9a, 8'h67, 8'hfb, 8'h4b, 8'hb5
	};

	localparam logic [7:0] AES_UUID [UUID_LEN] = '{
		8'h31, 8'hc1, 8'hf2, 8'he6, 8'hbf, 8'h71, 8'h43, 8'h50,
		8'hbe, 8'h58, 8'h05, 8'h21, 8'h6a, 8'hfc, 8'h5a, 8'hff
	};

	localparam logic [31:0] VERSION_RESET = 32'h0003_0001;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// One classified input item.
	typedef struct packed {
		logic [7:0]          data;
		logic                restart;
		logic                last;
		logic [MAGIC_LEN-1:0] magic_hit;
		logic [UUID_LEN-1:0]  uuid_hit;
	} entry_t;

endpackage

[hdl/kdbx_front.sv]
// Front of the header parser: accepts input items, compares each byte against every
// position of the signature and the cipher UUID, and queues the classified item.
// Depends on kdbx_pkg.
`timescale 1ns / 1ps

module kdbx_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      in_byte,
	input  logic            restart,
	input  logic            stream_end,
	output logic            q_valid,
	output kdbx_pkg::entry_t q_entry,
	input  logic            q_take
);

	kdbx_pkg::entry_t           mem_q [kdbx_pkg::QDEPTH];
	kdbx_pkg::entry_t           ent;
	logic [kdbx_pkg::QAW-1:0]   wr_ptr_q;
	logic [kdbx_pkg::QAW-1:0]   rd_ptr_q;
	logic [kdbx_pkg::QAW:0]     count_q;
	logic                       push;
	logic                       pop;

	always_comb begin
		ent.data    = in_byte;
		ent.restart = restart;
		ent.last    = stream_end;
		for (int k = 0; k < kdbx_pkg::MAGIC_LEN; k++) begin
			ent.magic_hit[k] = (in_byte == kdbx_pkg::MAGIC[k]);
		end
		for (int k = 0; k < kdbx_pkg::UUID_LEN; k++) begin
			ent.uuid_hit[k] = (in_byte == kdbx_pkg::AES_UUID[k]);
		end
	end

	assign in_stall = (count_q == (kdbx_pkg::QAW+1)'(kdbx_pkg::QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign pop      = q_valid && q_take;
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/kdbx_back.sv]
// Back of the header parser: the phase sequencer, field checks and the output register.
// Takes one classified item per cycle from the front queue while the output is not stalled.
// Depends on kdbx_pkg.
`timescale 1ns / 1ps

module kdbx_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	input  logic             q_valid,
	input  kdbx_pkg::entry_t q_entry,
	output logic             q_take,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       phase,
	output logic [7:0]       field_id,
	output logic [15:0]      payload_offset,
	output logic             payload_valid,
	output logic             field_done,
	output logic [63:0]      field_value,
	output logic             value_valid,
	output logic             header_done,
	output logic [3:0]       error_code
);

	logic [31:0] version_q;
	logic [2:0]  phase_q;
	logic [15:0] cnt_q;
	logic [7:0]  id_q;
	logic [15:0] len_q;
	logic [63:0] acc_q;
	logic        cmp_q;
	logic [3:0]  err_q;
	logic        out_valid_q;

	// Next state.
	logic [2:0]  ph_n;
	logic [15:0] cnt_n;
	logic [7:0]  id_n;
	logic [15:0] len_n;
	logic [63:0] acc_n;
	logic        cmp_n;
	logic [3:0]  err_n;

	// Result of this item.
	logic [2:0]  r_phase;
	logic [7:0]  r_id;
	logic [15:0] r_off;
	logic        r_pv;
	logic        r_fdone;
	logic [63:0] r_val;
	logic        r_vvalid;
	logic        r_hdone;

	logic        finish;
	logic [3:0]  err;
	logic [3:0]  chk_err;
	logic        chk_has_val;
	logic        adv;

	always_comb begin
		// Restart clears the parse state ahead of this byte.
		if (q_entry.restart) begin
			ph_n  = kdbx_pkg::PH_MAGIC;
			cnt_n = '0;
			id_n  = '0;
			len_n = '0;
			acc_n = '0;
			cmp_n = 1'b1;
			err_n = kdbx_pkg::ERR_OK;
		end else begin
			ph_n  = phase_q;
			cnt_n = cnt_q;
			id_n  = id_q;
			len_n = len_q;
			acc_n = acc_q;
			cmp_n = cmp_q;
			err_n = err_q;
		end

		r_phase  = ph_n;
		r_id     = '0;
		r_off    = '0;
		r_pv     = 1'b0;
		r_fdone  = 1'b0;
		r_val    = '0;
		r_vvalid = 1'b0;
		r_hdone  = 1'b0;
		finish   = 1'b0;
		err      = kdbx_pkg::ERR_OK;

		case (r_phase)
			kdbx_pkg::PH_MAGIC: begin
				if (!q_entry.magic_hit[cnt_n[2:0]]) cmp_n = 1'b0;
				if (cnt_n >= 16'd7) begin
					if (!cmp_n) err = kdbx_pkg::ERR_MAGIC;
					ph_n  = kdbx_pkg::PH_VERSION;
					cnt_n = '0;
					cmp_n = 1'b1;
					acc_n = '0;
				end else begin
					cnt_n = cnt_n + 16'd1;
				end
			end
			kdbx_pkg::PH_VERSION: begin
				acc_n[{cnt_n[1:0], 3'b000} +: 8] = acc_n[{cnt_n[1:0], 3'b000} +: 8] | q_entry.data;
				if (cnt_n >= 16'd3) begin
					if (acc_n[31:0] != version_q) err = kdbx_pkg::ERR_VERSION;
					ph_n  = kdbx_pkg::PH_ID;
					cnt_n = '0;
					acc_n = '0;
				end else begin
					cnt_n = cnt_n + 16'd1;
				end
			end
			kdbx_pkg::PH_ID: begin
				id_n  = q_entry.data;
				r_id  = q_entry.data;
				cnt_n = '0;
				acc_n = '0;
				cmp_n = 1'b1;
				ph_n  = kdbx_pkg::PH_LEN_LO;
			end
			kdbx_pkg::PH_LEN_LO: begin
				r_id  = id_n;
				len_n = {8'h00, q_entry.data};
				ph_n  = kdbx_pkg::PH_LEN_HI;
			end
			kdbx_pkg::PH_LEN_HI: begin
				r_id  = id_n;
				len_n = {q_entry.data, len_n[7:0]};
				if (len_n == '0) finish = 1'b1;
				else ph_n = kdbx_pkg::PH_PAYLOAD;
			end
			kdbx_pkg::PH_PAYLOAD: begin
				r_id  = id_n;
				r_off = cnt_n;
				r_pv  = 1'b1;
				if (cnt_n[15:3] == '0) begin
					acc_n[{cnt_n[2:0], 3'b000} +: 8] =
						acc_n[{cnt_n[2:0], 3'b000} +: 8] | q_entry.data;
				end
				if (cnt_n[15:4] != '0 || !q_entry.uuid_hit[cnt_n[3:0]]) cmp_n = 1'b0;
				if (({1'b0, cnt_n} + 17'd1) >= {1'b0, len_n}) finish = 1'b1;
				else cnt_n = cnt_n + 16'd1;
			end
			default: begin
			end
		endcase

		// Field check by id; it only counts when the field ends.
		chk_has_val = 1'b0;
		chk_err     = kdbx_pkg::ERR_OK;
		case (id_n)
			kdbx_pkg::FID_END, kdbx_pkg::FID_COMMENT,
			kdbx_pkg::FID_XFORM_SEED, kdbx_pkg::FID_STREAM_KEY: begin
				chk_err = kdbx_pkg::ERR_OK;
			end
			kdbx_pkg::FID_CIPHER: begin
				if (len_n != kdbx_pkg::LEN_CIPHER || !cmp_n) chk_err = kdbx_pkg::ERR_CIPHER;
			end
			kdbx_pkg::FID_COMPRESSION: begin
				if (len_n != kdbx_pkg::LEN_COMPR || acc_n[63:1] != '0) begin
					chk_err = kdbx_pkg::ERR_COMPRESSION;
				end else begin
					chk_has_val = 1'b1;
				end
			end
			kdbx_pkg::FID_MASTER_SEED: begin
				if (len_n != kdbx_pkg::LEN_SEED) chk_err = kdbx_pkg::ERR_SEED_LEN;
			end
			kdbx_pkg::FID_ROUNDS: begin
				if (len_n != kdbx_pkg::LEN_ROUNDS) chk_err = kdbx_pkg::ERR_ROUNDS_LEN;
				else chk_has_val = 1'b1;
			end
			kdbx_pkg::FID_IV: begin
				if (len_n != kdbx_pkg::LEN_IV) chk_err = kdbx_pkg::ERR_IV_LEN;
			end
			kdbx_pkg::FID_START_BYTES: begin
				if (len_n != kdbx_pkg::LEN_START) chk_err = kdbx_pkg::ERR_START_LEN;
			end
			kdbx_pkg::FID_STREAM_ID: begin
				if (len_n != kdbx_pkg::LEN_SID) chk_err = kdbx_pkg::ERR_STREAM_LEN;
				else chk_has_val = 1'b1;
			end
			default: begin
				chk_err = kdbx_pkg::ERR_BAD_ID;
			end
		endcase

		if (finish) begin
			err = chk_err;
			if (chk_err == kdbx_pkg::ERR_OK) begin
				r_fdone = 1'b1;
				if (chk_has_val) begin
					r_vvalid = 1'b1;
					r_val    = acc_n;
				end
				if (id_n == kdbx_pkg::FID_END) begin
					r_hdone = 1'b1;
					ph_n    = kdbx_pkg::PH_DONE;
				end else begin
					ph_n = kdbx_pkg::PH_ID;
				end
			end
			cnt_n = '0;
		end

		if (err != kdbx_pkg::ERR_OK) begin
			err_n = err;
			ph_n  = kdbx_pkg::PH_ERROR;
		end else if (q_entry.last && ph_n != kdbx_pkg::PH_DONE && ph_n != kdbx_pkg::PH_ERROR) begin
			err_n = kdbx_pkg::ERR_TRUNCATED;
			ph_n  = kdbx_pkg::PH_ERROR;
		end
	end

	assign adv    = q_valid && (!out_valid_q || !out_stall);
	assign q_take = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q   <= kdbx_pkg::VERSION_RESET;
			phase_q     <= kdbx_pkg::PH_MAGIC;
			cnt_q       <= '0;
			id_q        <= '0;
			len_q       <= '0;
			acc_q       <= '0;
			cmp_q       <= 1'b1;
			err_q       <= kdbx_pkg::ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				version_q <= cfg_wr_data;
			end
			if (adv) begin
				phase_q <= ph_n;
				cnt_q   <= cnt_n;
				id_q    <= id_n;
				len_q   <= len_n;
				acc_q   <= acc_n;
				cmp_q   <= cmp_n;
				err_q   <= err_n;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; payload only, held while stalled.
	always_ff @(posedge clk) begin
		if (adv) begin
			phase          <= r_phase;
			field_id       <= r_id;
			payload_offset <= r_off;
			payload_valid  <= r_pv;
			field_done     <= r_fdone;
			field_value    <= r_val;
			value_valid    <= r_vvalid;
			header_done    <= r_hdone;
			error_code     <= err_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/kdbx_header_tlv_parser.sv]
// Top level of the streaming database header field parser.
// Instantiates kdbx_front (classify and queue) and kdbx_back (sequencer and result register).
// Depends on kdbx_pkg, kdbx_front and kdbx_back.
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_stall     in_byte, restart, stream_end
// output    out_valid / out_stall   phase, field_id, payload_offset, payload_valid,
//                                   field_done, field_value, value_valid, header_done,
//                                   error_code
// config    cfg_wr_en               cfg_wr_data (expected version)
//
// One item is taken per cycle while in_stall is low; its result passes through the front
// queue and then the result register in the back before it is offered.
// The phase sequencer in the back handles one item per cycle while the output is not stalled.
// An asynchronous active-low reset empties the queue, clears the parse state and loads
// the expected version with 0x00030001. An output stall holds the result register and
// the sequencer; the four-entry queue takes items until it fills, then in_stall rises.

module kdbx_header_tlv_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        restart,
	input  logic        stream_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  phase,
	output logic [7:0]  field_id,
	output logic [15:0] payload_offset,
	output logic        payload_valid,
	output logic        field_done,
	output logic [63:0] field_value,
	output logic        value_valid,
	output logic        header_done,
	output logic [3:0]  error_code
);

	// Queue handshake between the two halves.
	logic             q_valid;
	logic             q_take;
	kdbx_pkg::entry_t q_entry;

	// The front compares every byte against all signature and UUID positions up front,
	// so the back only has to select one match bit by its byte counter.
	kdbx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.restart    (restart),
		.stream_end (stream_end),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_take     (q_take)
	);

	// The back walks the phases, checks each field when it ends and keeps the first
	// error sticky until an item with restart set arrives.
	kdbx_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_take         (q_take),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.phase          (phase),
		.field_id       (field_id),
		.payload_offset (payload_offset),
		.payload_valid  (payload_valid),
		.field_done     (field_done),
		.field_value    (field_value),
		.value_valid    (value_valid),
		.header_done    (header_done),
		.error_code     (error_code)
	);

endmodule

[hdl/kdbx_checker.sv]
// Port-level assertions for the header parser and the bind that attaches them.
// Depends on kdbx_pkg and kdbx_header_tlv_parser.
`timescale 1ns / 1ps

module kdbx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  phase,
	input logic [7:0]  field_id,
	input logic        payload_valid,
	input logic        field_done,
	input logic        value_valid,
	input logic        header_done,
	input logic [3:0]  error_code
);

	// A stalled result stays offered with its phase, error code and field_done unchanged.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase) && $stable(error_code)
		&& $stable(field_done))
		else $error("stalled result changed");

	// Payload bytes are tagged only in the payload phase.
	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> phase == kdbx_pkg::PH_PAYLOAD)
		else $error("payload tag outside payload phase");

	// End of header is a clean completion of the end field.
	a_header_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_done |-> field_done && field_id == kdbx_pkg::FID_END
		&& error_code == kdbx_pkg::ERR_OK)
		else $error("header done without clean end field");

	// A decoded value only comes with a completed field.
	a_value_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_valid |-> field_done)
		else $error("value without completed field");

	// A byte seen in the error phase reports a sticky error.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == kdbx_pkg::PH_ERROR |-> error_code != kdbx_pkg::ERR_OK)
		else $error("error phase without error code");

endmodule

bind kdbx_header_tlv_parser kdbx_checker u_kdbx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.phase         (phase),
	.field_id      (field_id),
	.payload_valid (payload_valid),
	.field_done    (field_done),
	.value_valid   (value_valid),
	.header_done   (header_done),
	.error_code    (error_code)
);

[dv/tb_top.sv]
// Self-checking testbench for kdbx_header_tlv_parser, the streaming header field parser.
// Builds byte streams of headers (good, damaged, cut short), predicts every byte's tag
// internally and checks the results in order; depends on kdbx_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;

	// Generous cycle budget; a correct run needs a small fraction of it.
	localparam int LIMIT = 400000;
	localparam int RANDOM_ITEMS = 720;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	// One result of the parser: the tag of one header byte.
	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  fid;
		logic [15:0] off;
		logic        pv;
		logic        fdone;
		logic [63:0] fval;
		logic        vvalid;
		logic        hdone;
		logic [3:0]  err;
	} byte_tag_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = '0;
	logic        restart = 1'b0;
	logic        stream_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  phase;
	logic [7:0]  field_id;
	logic [15:0] payload_offset;
	logic        payload_valid;
	logic        field_done;
	logic [63:0] field_value;
	logic        value_valid;
	logic        header_done;
	logic [3:0]  error_code;

	kdbx_header_tlv_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.restart(restart),
		.stream_end(stream_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.phase(phase),
		.field_id(field_id),
		.payload_offset(payload_offset),
		.payload_valid(payload_valid),
		.field_done(field_done),
		.field_value(field_value),
		.value_valid(value_valid),
		.header_done(header_done),
		.error_code(error_code)
	);

	// Our own copy of the parser state, updated once per accepted item.
	logic [31:0] want_version = kdbx_pkg::VERSION_RESET;
	logic [2:0]  p_phase = kdbx_pkg::PH_MAGIC;
	logic [15:0] p_count = '0;
	logic [7:0]  p_id = '0;
	logic [15:0] p_len = '0;
	logic [63:0] p_acc = '0;
	logic        p_match = 1'b1;
	logic [3:0]  p_err = kdbx_pkg::ERR_OK;

	byte_tag_t   pending_tags[$];
	logic [7:0]  hdr_bytes[$];
	int unsigned sent_items = 0;
	int unsigned fail_count = 0;
	int unsigned cycles = 0;

	// Sender burst shaping and receiver stall shaping.
	int          burst_left = 0;
	int          gap_left = 0;
	bit          no_gaps = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_tags.size());
			$display("status: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- prediction

	function automatic void clear_parse();
		p_phase = kdbx_pkg::PH_MAGIC;
		p_count = '0;
		p_id = '0;
		p_len = '0;
		p_acc = '0;
		p_match = 1'b1;
		p_err = kdbx_pkg::ERR_OK;
	endfunction

	// Verdict on a field that has just ended; has_value marks the integer fields.
	function automatic logic [3:0] field_verdict(output bit has_value);
		has_value = 1'b0;
		case (p_id)
		kdbx_pkg::FID_END, kdbx_pkg::FID_COMMENT, kdbx_pkg::FID_XFORM_SEED,
		kdbx_pkg::FID_STREAM_KEY: return kdbx_pkg::ERR_OK;
		kdbx_pkg::FID_CIPHER: return (p_len == kdbx_pkg::LEN_CIPHER && p_match) ?
			kdbx_pkg::ERR_OK : kdbx_pkg::ERR_CIPHER;
		kdbx_pkg::FID_COMPRESSION: begin
			if (p_len != kdbx_pkg::LEN_COMPR || p_acc > 64'd1)
				return kdbx_pkg::ERR_COMPRESSION;
			has_value = 1'b1;
			return kdbx_pkg::ERR_OK;
		end
		kdbx_pkg::FID_MASTER_SEED: return (p_len == kdbx_pkg::LEN_SEED) ?
			kdbx_pkg::ERR_OK : kdbx_pkg::ERR_SEED_LEN;
		kdbx_pkg::FID_ROUNDS: begin
			if (p_len != kdbx_pkg::LEN_ROUNDS)
				return kdbx_pkg::ERR_ROUNDS_LEN;
			has_value = 1'b1;
			return kdbx_pkg::ERR_OK;
		end
		kdbx_pkg::FID_IV: return (p_len == kdbx_pkg::LEN_IV) ?
			kdbx_pkg::ERR_OK : kdbx_pkg::ERR_IV_LEN;
		kdbx_pkg::FID_START_BYTES: return (p_len == kdbx_pkg::LEN_START) ?
			kdbx_pkg::ERR_OK : kdbx_pkg::ERR_START_LEN;
		kdbx_pkg::FID_STREAM_ID: begin
			if (p_len != kdbx_pkg::LEN_SID)
				return kdbx_pkg::ERR_STREAM_LEN;
			has_value = 1'b1;
			return kdbx_pkg::ERR_OK;
		end
		default: return kdbx_pkg::ERR_BAD_ID;
		endcase
	endfunction

	// Tag of one header byte, advancing the predicted parse state.
	function automatic byte_tag_t tag_byte(logic [7:0] b, logic rs, logic last);
		byte_tag_t t;
		logic [3:0] err;
		bit finish;
		bit has_value;
		t = '0;
		err = kdbx_pkg::ERR_OK;
		finish = 1'b0;
		if (rs)
			clear_parse();
		t.phase = p_phase;
		case (p_phase)
		kdbx_pkg::PH_MAGIC: begin
			// A wrong signature byte only shows once all eight have gone by.
			if (b != kdbx_pkg::MAGIC[p_count[2:0]])
				p_match = 1'b0;
			if (p_count >= 16'd7) begin
				if (!p_match)
					err = kdbx_pkg::ERR_MAGIC;
				p_phase = kdbx_pkg::PH_VERSION;
				p_count = '0;
				p_match = 1'b1;
				p_acc = '0;
			end else
				p_count++;
		end
		kdbx_pkg::PH_VERSION: begin
			p_acc |= 64'(b) << (8 * p_count[1:0]);
			if (p_count >= 16'd3) begin
				if (p_acc[31:0] != want_version)
					err = kdbx_pkg::ERR_VERSION;
				p_phase = kdbx_pkg::PH_ID;
				p_count = '0;
				p_acc = '0;
			end else
				p_count++;
		end
		kdbx_pkg::PH_ID: begin
			p_id = b;
			t.fid = b;
			p_count = '0;
			p_acc = '0;
			p_match = 1'b1;
			p_phase = kdbx_pkg::PH_LEN_LO;
		end
		kdbx_pkg::PH_LEN_LO: begin
			t.fid = p_id;
			p_len = {8'h00, b};
			p_phase = kdbx_pkg::PH_LEN_HI;
		end
		kdbx_pkg::PH_LEN_HI: begin
			t.fid = p_id;
			p_len[15:8] = b;
			// An empty field ends on its length high byte.
			if (p_len == 16'd0)
				finish = 1'b1;
			else
				p_phase = kdbx_pkg::PH_PAYLOAD;
		end
		kdbx_pkg::PH_PAYLOAD: begin
			t.fid = p_id;
			t.off = p_count;
			t.pv = 1'b1;
			if (p_count < 16'd8)
				p_acc |= 64'(b) << (8 * p_count[2:0]);
			if (p_count >= 16'd16 || b != kdbx_pkg::AES_UUID[p_count[3:0]])
				p_match = 1'b0;
			if (32'(p_count) + 32'd1 >= 32'(p_len))
				finish = 1'b1;
			else
				p_count++;
		end
		default: ;
		endcase

		if (finish) begin
			err = field_verdict(has_value);
			if (err == kdbx_pkg::ERR_OK) begin
				t.fdone = 1'b1;
				if (has_value) begin
					t.vvalid = 1'b1;
					t.fval = p_acc;
				end
				if (p_id == kdbx_pkg::FID_END) begin
					t.hdone = 1'b1;
					p_phase = kdbx_pkg::PH_DONE;
				end else
					p_phase = kdbx_pkg::PH_ID;
			end
			p_count = '0;
		end

		// An error from the byte itself wins over truncation.
		if (err != kdbx_pkg::ERR_OK) begin
			p_err = err;
			p_phase = kdbx_pkg::PH_ERROR;
		end else if (last && p_phase != kdbx_pkg::PH_DONE && p_phase != kdbx_pkg::PH_ERROR) begin
			p_err = kdbx_pkg::ERR_TRUNCATED;
			p_phase = kdbx_pkg::PH_ERROR;
		end
		t.err = p_err;
		return t;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_one(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Every accepted result is matched against the oldest predicted tag.
	always @(posedge clk) begin
		byte_tag_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_tags.size() == 0) begin
				$display("%0t: unexpected result, phase %0d error_code %0d", $time, phase,
					error_code);
				fail_count++;
			end else begin
				want = pending_tags.pop_front();
				check_one("phase", 64'(want.phase), 64'(phase));
				check_one("field_id", 64'(want.fid), 64'(field_id));
				check_one("payload_offset", 64'(want.off), 64'(payload_offset));
				check_one("payload_valid", 64'(want.pv), 64'(payload_valid));
				check_one("field_done", 64'(want.fdone), 64'(field_done));
				check_one("field_value", want.fval, field_value);
				check_one("value_valid", 64'(want.vvalid), 64'(value_valid));
				check_one("header_done", 64'(want.hdone), 64'(header_done));
				check_one("error_code", 64'(want.err), 64'(error_code));
			end
		end
	end

	// Receiver: changing stall patterns, plus a long hold-off on request so that
	// the internal queue fills and the input side has to stall.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
			STALL_PERIODIC: out_stall <= (mode_left % 3 == 0);
			default: out_stall <= ($urandom_range(0, 99) < 65);
			endcase
		end
	end

	// ---------------------------------------------------------------- driving

	// Offers one item at a falling edge and holds it until it is accepted.
	task automatic send_item(input logic [7:0] b, input logic rs, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (no_gaps)
			gap_left = 0;
		while (gap_left > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
			gap_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte <= b;
		restart <= rs;
		stream_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_tags.push_back(tag_byte(b, rs, last));
		burst_left--;
		sent_items++;
	endtask

	// Drops the input and waits until every predicted tag has been seen.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		restart <= 1'b0;
		stream_end <= 1'b0;
		while (pending_tags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_version(input logic [31:0] v);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		want_version = v;
	endtask

	// Sends the built stream, optionally with restart on the first byte and
	// stream_end on the last one.
	task automatic play_bytes(input bit rs_first, input bit se_last);
		foreach (hdr_bytes[i])
			send_item(hdr_bytes[i], rs_first && i == 0, se_last && i == hdr_bytes.size() - 1);
		hdr_bytes.delete();
	endtask

	// ---------------------------------------------------------------- stream building

	function automatic void put_magic(bit corrupt);
		int k;
		k = $urandom_range(0, kdbx_pkg::MAGIC_LEN - 1);
		for (int i = 0; i < kdbx_pkg::MAGIC_LEN; i++)
			hdr_bytes.push_back((corrupt && i == k) ?
				kdbx_pkg::MAGIC[i] ^ 8'($urandom_range(1, 255)) : kdbx_pkg::MAGIC[i]);
	endfunction

	function automatic void put_version(logic [31:0] v);
		for (int i = 0; i < 4; i++)
			hdr_bytes.push_back(v[8*i +: 8]);
	endfunction

	// Cipher payloads carry the AES UUID, integer fields carry val little-endian.
	function automatic void put_field(logic [7:0] id, logic [15:0] len, logic [63:0] val);
		hdr_bytes.push_back(id);
		hdr_bytes.push_back(len[7:0]);
		hdr_bytes.push_back(len[15:8]);
		for (int i = 0; i < int'(len); i++) begin
			if (id == kdbx_pkg::FID_CIPHER && i < kdbx_pkg::UUID_LEN)
				hdr_bytes.push_back(kdbx_pkg::AES_UUID[i]);
			else if (i < 8 && (id == kdbx_pkg::FID_COMPRESSION || id == kdbx_pkg::FID_ROUNDS
				|| id == kdbx_pkg::FID_STREAM_ID))
				hdr_bytes.push_back(val[8*i +: 8]);
			else
				hdr_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic logic [15:0] legal_len(logic [7:0] id);
		case (id)
		kdbx_pkg::FID_CIPHER: return kdbx_pkg::LEN_CIPHER;
		kdbx_pkg::FID_COMPRESSION: return kdbx_pkg::LEN_COMPR;
		kdbx_pkg::FID_MASTER_SEED: return kdbx_pkg::LEN_SEED;
		kdbx_pkg::FID_ROUNDS: return kdbx_pkg::LEN_ROUNDS;
		kdbx_pkg::FID_IV: return kdbx_pkg::LEN_IV;
		kdbx_pkg::FID_START_BYTES: return kdbx_pkg::LEN_START;
		kdbx_pkg::FID_STREAM_ID: return kdbx_pkg::LEN_SID;
		default: return 16'($urandom_range(0, 6));
		endcase
	endfunction

	function automatic void put_prefix();
		put_magic(1'b0);
		put_version(want_version);
	endfunction

	// ---------------------------------------------------------------- tests

	// A complete header with every integer field, a zero-length field and
	// trailing bytes after the end field; stream_end after done changes nothing.
	task automatic test_good_header();
		put_prefix();
		put_field(kdbx_pkg::FID_COMMENT, 16'd0, '0);
		put_field(kdbx_pkg::FID_CIPHER, kdbx_pkg::LEN_CIPHER, '0);
		put_field(kdbx_pkg::FID_COMPRESSION, kdbx_pkg::LEN_COMPR, 64'd1);
		put_field(kdbx_pkg::FID_ROUNDS, kdbx_pkg::LEN_ROUNDS, '1);
		put_field(kdbx_pkg::FID_STREAM_ID, kdbx_pkg::LEN_SID, 64'hffff_ffff);
		put_field(kdbx_pkg::FID_END, 16'd4, '0);
		hdr_bytes.push_back(8'hff);
		hdr_bytes.push_back(8'h00);
		play_bytes(1'b1, 1'b1);
	endtask

	// Bad signature: flagged on the eighth byte, then everything is tagged as error.
	task automatic test_magic_error();
		put_magic(1'b1);
		put_version(want_version);
		hdr_bytes.push_back(8'h00);
		play_bytes(1'b1, 1'b1);
	endtask

	// The version register at both extremes and back at its reset value.
	task automatic test_version_register();
		write_version(32'hffff_ffff);
		put_prefix();
		put_field(kdbx_pkg::FID_END, 16'd0, '0);
		play_bytes(1'b1, 1'b0);
		put_magic(1'b0);
		put_version(32'hffff_fffe);
		put_field(kdbx_pkg::FID_END, 16'd0, '0);
		play_bytes(1'b1, 1'b0);
		write_version(32'h0000_0000);
		put_prefix();
		put_field(kdbx_pkg::FID_COMPRESSION, kdbx_pkg::LEN_COMPR, 64'd0);
		put_field(kdbx_pkg::FID_END, 16'd0, '0);
		play_bytes(1'b1, 1'b0);
		write_version(kdbx_pkg::VERSION_RESET);
	endtask

	task automatic bad_field(input logic [7:0] id, input logic [15:0] len, input logic [63:0] val);
		put_prefix();
		put_field(id, len, val);
		hdr_bytes.push_back(8'($urandom_range(0, 255)));
		play_bytes(1'b1, 1'b0);
	endtask

	// Each length and content check, unknown ids at both ends of their range, and
	// an empty field of a checked id, which fails at its length high byte.
	task automatic test_field_checks();
		bad_field(kdbx_pkg::FID_CIPHER, kdbx_pkg::LEN_CIPHER - 16'd1, '0);
		put_prefix();
		put_field(kdbx_pkg::FID_CIPHER, kdbx_pkg::LEN_CIPHER, '0);
		hdr_bytes[hdr_bytes.size() - 5] ^= 8'h80;
		play_bytes(1'b1, 1'b0);
		bad_field(kdbx_pkg::FID_COMPRESSION, kdbx_pkg::LEN_COMPR, 64'd2);
		bad_field(kdbx_pkg::FID_COMPRESSION, kdbx_pkg::LEN_COMPR - 16'd1, 64'd0);
		bad_field(kdbx_pkg::FID_MASTER_SEED, kdbx_pkg::LEN_SEED - 16'd1, '0);
		bad_field(kdbx_pkg::FID_ROUNDS, kdbx_pkg::LEN_ROUNDS - 16'd1, '0);
		bad_field(kdbx_pkg::FID_IV, kdbx_pkg::LEN_IV - 16'd1, '0);
		bad_field(kdbx_pkg::FID_START_BYTES, kdbx_pkg::LEN_START - 16'd1, '0);
		bad_field(kdbx_pkg::FID_STREAM_ID, kdbx_pkg::LEN_SID + 16'd1, '0);
		bad_field(8'd11, 16'd2, '0);
		bad_field(8'd255, 16'd0, '0);
		bad_field(kdbx_pkg::FID_ROUNDS, 16'd0, '0);
	endtask

	// Streams that stop early: inside the signature, on the last byte of a good
	// field (done and truncated together), at an id, and a restart mid-payload.
	task automatic test_truncation();
		put_magic(1'b0);
		hdr_bytes = hdr_bytes[0:3];
		play_bytes(1'b1, 1'b1);
		put_prefix();
		put_field(kdbx_pkg::FID_IV, kdbx_pkg::LEN_IV, '0);
		play_bytes(1'b1, 1'b1);
		put_prefix();
		hdr_bytes.push_back(kdbx_pkg::FID_MASTER_SEED);
		play_bytes(1'b1, 1'b1);
		put_prefix();
		put_field(kdbx_pkg::FID_MASTER_SEED, kdbx_pkg::LEN_SEED, '0);
		hdr_bytes = hdr_bytes[0:20];
		play_bytes(1'b1, 1'b0);
	endtask

	// The largest length a field can declare; cut off after a few payload bytes.
	task automatic test_long_field();
		put_prefix();
		put_field(kdbx_pkg::FID_COMMENT, 16'hffff, '0);
		hdr_bytes = hdr_bytes[0:35];
		play_bytes(1'b1, 1'b1);
	endtask

	// The receiver holds off while the sender keeps offering a long header.
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_req = 1'b1;
		put_prefix();
		put_field(kdbx_pkg::FID_MASTER_SEED, kdbx_pkg::LEN_SEED, '0);
		put_field(kdbx_pkg::FID_ROUNDS, kdbx_pkg::LEN_ROUNDS, {$urandom, $urandom});
		put_field(kdbx_pkg::FID_END, 16'd0, '0);
		play_bytes(1'b1, 1'b0);
		no_gaps = 1'b0;
	endtask

	// A mostly well-formed header with random fields and content, now and then
	// damaged by one bad field, a bad prefix or an early end.
	task automatic rand_header();
		int nf;
		int k;
		int cut;
		bit se;
		logic [7:0] id;
		put_magic($urandom_range(0, 19) == 0);
		put_version(($urandom_range(0, 19) == 0) ? $urandom : want_version);
		nf = $urandom_range(0, 4);
		repeat (nf) begin
			id = 8'($urandom_range(1, 10));
			put_field(id, legal_len(id), (id == kdbx_pkg::FID_COMPRESSION) ?
				64'($urandom_range(0, 1)) : {$urandom, $urandom});
		end
		case ($urandom_range(0, 9))
		0: begin
			id = 8'($urandom_range(2, 10));
			put_field(id, legal_len(id) ^ (16'd1 << $urandom_range(0, 5)), '0);
		end
		1: put_field(8'($urandom_range(11, 255)), 16'($urandom_range(0, 5)), '0);
		2: put_field(kdbx_pkg::FID_COMPRESSION, kdbx_pkg::LEN_COMPR,
			64'($urandom_range(2, 32'hffff_ffff)));
		3: begin
			put_field(kdbx_pkg::FID_CIPHER, kdbx_pkg::LEN_CIPHER, '0);
			k = $urandom_range(1, kdbx_pkg::UUID_LEN);
			hdr_bytes[hdr_bytes.size() - k] ^= 8'($urandom_range(1, 255));
		end
		default: ;
		endcase
		put_field(kdbx_pkg::FID_END, 16'($urandom_range(0, 4)), '0);
		repeat ($urandom_range(0, 3))
			hdr_bytes.push_back(8'($urandom_range(0, 255)));
		se = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 6) == 0) begin
			cut = $urandom_range(1, hdr_bytes.size());
			while (hdr_bytes.size() > cut)
				void'(hdr_bytes.pop_back());
			se = ($urandom_range(0, 3) != 0);
		end
		play_bytes(1'b1, se);
	endtask

	task automatic test_random_headers();
		int unsigned stop_at;
		int sel;
		stop_at = sent_items + RANDOM_ITEMS;
		while (sent_items < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 6)
				write_version(($urandom_range(0, 2) == 0) ? kdbx_pkg::VERSION_RESET : $urandom);
			else if (sel < 20) begin
				// Noise: raw bytes with occasional restarts and stream ends.
				repeat ($urandom_range(4, 24))
					send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
						$urandom_range(0, 15) == 0);
			end else
				rand_header();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		clear_parse();
		want_version = kdbx_pkg::VERSION_RESET;

		test_good_header();
		test_magic_error();
		test_version_register();
		test_field_checks();
		test_truncation();
		test_long_field();
		test_backpressure();
		test_random_headers();

		wait_idle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[files.f]
hdl/kdbx_pkg.sv
hdl/kdbx_front.sv
hdl/kdbx_back.sv
hdl/kdbx_header_tlv_parser.sv
hdl/kdbx_checker.sv
dv/tb_top.sv
